[sv/chrl_pkg.sv]
// ----------------------------------------------------------------------------
// chrl_pkg
// Shared types and constants of the consistent hash ring lookup block.
// ----------------------------------------------------------------------------
package chrl_pkg;

   localparam int unsigned HOST_W = 7;
   localparam int unsigned HASH_W = 32;
   localparam int unsigned KEY_W  = 64;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned STAT_W = 2;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key_value;
      logic [HASH_W-1:0] point_hash;
      logic [HOST_W-1:0] host_id;
   } req_type;

   typedef struct packed {
      logic [HOST_W-1:0] chosen_host;
      logic [HASH_W-1:0] key_hash;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HASH,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_LOOKUP_RD,
      ST_LOOKUP_WAIT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_REM_RD,
      ST_REM_WAIT,
      ST_RESP
   } state_type;

   function automatic logic [HASH_W-1:0] oaat_round(logic [HASH_W-1:0] h,
                                                    logic [7:0] b);
      logic [HASH_W-1:0] t;
      t = h + {{(HASH_W-8){b[7]}}, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [HASH_W-1:0] oaat_final(logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

endpackage

[sv/chrl_if.sv]
// ----------------------------------------------------------------------------
// chrl_req_if / chrl_rsp_if
// Valid/ready channels of the consistent hash ring lookup block.
// ----------------------------------------------------------------------------
interface chrl_req_if;
   logic               valid;
   logic               ready;
   chrl_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface chrl_rsp_if;
   logic               valid;
   logic               ready;
   chrl_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/consistent_hash_ring_lookup.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup
// Sorted ring of (hash, host) points in one RAM; lookup, add and remove.
// ----------------------------------------------------------------------------
// Lookup: KEY_BYTES hash rounds, one per cycle, then a binary search of
// about log2(RING_SIZE)+1 RAM reads, each followed by a wait state (single RAM port).
// Add: search, then a read and a write per shifted entry. Remove: read each point.
// One item in flight at a time; the result register lets the next transfer in
// while a result waits. Reset clears the point count and control state; RAM
// content is not cleared.
module consistent_hash_ring_lookup #(
   parameter int unsigned RING_SIZE = 4096,
   parameter int unsigned KEY_BYTES = 8
) (
   input logic clock,
   input logic reset,
   chrl_req_if.sink   req,
   chrl_rsp_if.source rsp
);
   localparam int unsigned AW = $clog2(RING_SIZE);
   localparam int unsigned CW = $clog2(RING_SIZE + 1);
   localparam int unsigned BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int unsigned EW = chrl_pkg::HASH_W + chrl_pkg::HOST_W;
   localparam logic [CW-1:0] SIZE_C = CW'(RING_SIZE);
   localparam logic [BW-1:0] LAST_B = BW'(KEY_BYTES - 1);

   chrl_pkg::state_type state_ff, state_in;
   chrl_pkg::req_type   item_ff, item_in;
   chrl_pkg::rsp_type   out_ff, out_in;
   chrl_pkg::rsp_type   res_ff, res_in;
   logic                out_valid_ff, out_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in, wp_ff, wp_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic [chrl_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [EW-1:0] carry_ff, carry_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [chrl_pkg::HASH_W-1:0] rd_hash, search_val;
   logic [chrl_pkg::HOST_W-1:0] rd_host;
   logic [CW-1:0] mid;
   logic          go_right;
   logic [7:0]    key_byte;

   chrl_ram #(.WIDTH(EW), .DEPTH(RING_SIZE)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign rd_hash    = ram_rdata[EW-1:chrl_pkg::HOST_W];
   assign rd_host    = ram_rdata[chrl_pkg::HOST_W-1:0];
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign search_val = (item_ff.mode == chrl_pkg::MODE_LOOKUP) ? hash_ff
                                                              : item_ff.point_hash;
   assign go_right   = (item_ff.mode == chrl_pkg::MODE_LOOKUP) ? (rd_hash < search_val)
                                                              : (rd_hash <= search_val);
   assign key_byte   = item_ff.key_value[{byte_ff, 3'b000} +: 8];

   assign req.ready   = (state_ff == chrl_pkg::ST_IDLE);
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chrl_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               unique case (req.payload.mode)
                  chrl_pkg::MODE_LOOKUP: state_in = chrl_pkg::ST_HASH;
                  chrl_pkg::MODE_ADD: begin
                     if (count_ff >= SIZE_C || req.payload.host_id == '0) begin
                        state_in = chrl_pkg::ST_RESP;
                     end else begin
                        state_in = chrl_pkg::ST_SEARCH;
                     end
                  end
                  chrl_pkg::MODE_REMOVE: state_in = chrl_pkg::ST_REM_RD;
                  default: state_in = chrl_pkg::ST_RESP;
               endcase
            end
         end
         chrl_pkg::ST_HASH: begin
            if (byte_ff == LAST_B) begin
               state_in = (count_ff == '0) ? chrl_pkg::ST_RESP : chrl_pkg::ST_SEARCH;
            end
         end
         chrl_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               state_in = chrl_pkg::ST_SEARCH_WAIT;
            end else if (item_ff.mode == chrl_pkg::MODE_LOOKUP) begin
               state_in = chrl_pkg::ST_LOOKUP_RD;
            end else begin
               state_in = (ptr_ff == lo_ff) ? chrl_pkg::ST_SHIFT_WR : chrl_pkg::ST_SHIFT_RD;
            end
         end
         chrl_pkg::ST_SEARCH_WAIT: state_in = chrl_pkg::ST_SEARCH;
         chrl_pkg::ST_LOOKUP_RD:   state_in = chrl_pkg::ST_LOOKUP_WAIT;
         chrl_pkg::ST_LOOKUP_WAIT: state_in = chrl_pkg::ST_RESP;
         chrl_pkg::ST_SHIFT_RD:    state_in = chrl_pkg::ST_SHIFT_WR;
         chrl_pkg::ST_SHIFT_WR: begin
            if (ptr_ff == lo_ff) begin
               state_in = chrl_pkg::ST_RESP;
            end else begin
               state_in = ((ptr_ff - 1'b1) == lo_ff) ? chrl_pkg::ST_SHIFT_WR
                                                     : chrl_pkg::ST_SHIFT_RD;
            end
         end
         chrl_pkg::ST_REM_RD: begin
            state_in = (ptr_ff >= count_ff) ? chrl_pkg::ST_RESP : chrl_pkg::ST_REM_WAIT;
         end
         chrl_pkg::ST_REM_WAIT:    state_in = chrl_pkg::ST_REM_RD;
         chrl_pkg::ST_RESP: begin
            state_in = (!out_valid_ff || rsp.ready) ? chrl_pkg::ST_IDLE : chrl_pkg::ST_RESP;
         end
         default:                  state_in = chrl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      out_in       = out_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      wp_in        = wp_ff;
      byte_in      = byte_ff;
      hash_in      = hash_ff;
      carry_in     = carry_ff;
      ram_we       = 1'b0;
      ram_addr     = ptr_ff[AW-1:0];
      ram_wdata    = carry_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         chrl_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.payload;
               res_in  = '0;
               byte_in = '0;
               hash_in = '0;
               lo_in   = '0;
               hi_in   = count_ff;
               ptr_in  = (req.payload.mode == chrl_pkg::MODE_ADD) ? count_ff : '0;
               wp_in   = '0;
               if (req.payload.mode == chrl_pkg::MODE_ADD && count_ff >= SIZE_C) begin
                  res_in.status = chrl_pkg::STAT_FULL;
               end
            end
         end
         chrl_pkg::ST_HASH: begin
            hash_in = chrl_pkg::oaat_round(hash_ff, key_byte);
            byte_in = byte_ff + 1'b1;
            if (byte_ff == LAST_B) begin
               hash_in         = chrl_pkg::oaat_final(chrl_pkg::oaat_round(hash_ff, key_byte));
               res_in.key_hash = hash_in;
               if (count_ff == '0) begin
                  res_in.status = chrl_pkg::STAT_EMPTY;
               end
            end
         end
         chrl_pkg::ST_SEARCH: begin
            ram_addr = mid[AW-1:0];
            if (lo_ff >= hi_ff && item_ff.mode == chrl_pkg::MODE_ADD) begin
               carry_in = {item_ff.point_hash, item_ff.host_id};
               if (ptr_ff == lo_ff) begin
                  ram_addr = ptr_ff[AW-1:0];
               end else begin
                  ram_addr = ptr_in[AW-1:0];
               end
            end
            if (lo_ff >= hi_ff && item_ff.mode == chrl_pkg::MODE_ADD && ptr_ff != lo_ff) begin
               ptr_in   = ptr_ff;
               ram_addr = AW'(ptr_ff - 1'b1);
            end
         end
         chrl_pkg::ST_SEARCH_WAIT: begin
            if (go_right) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         chrl_pkg::ST_LOOKUP_RD: begin
            ram_addr = (lo_ff >= count_ff) ? '0 : lo_ff[AW-1:0];
         end
         chrl_pkg::ST_LOOKUP_WAIT: begin
            res_in.chosen_host = rd_host;
         end
         chrl_pkg::ST_SHIFT_RD: begin
            ram_addr = AW'(ptr_ff - 1'b1);
         end
         chrl_pkg::ST_SHIFT_WR: begin
            ram_we   = 1'b1;
            ram_addr = ptr_ff[AW-1:0];
            if (ptr_ff == lo_ff) begin
               ram_wdata = {item_ff.point_hash, item_ff.host_id};
               count_in  = count_ff + 1'b1;
            end else begin
               ram_wdata = ram_rdata;
               ptr_in    = ptr_ff - 1'b1;
            end
            if (ptr_ff != lo_ff && (ptr_ff - 1'b1) == lo_ff) begin
               ram_addr = ptr_ff[AW-1:0];
            end
         end
         chrl_pkg::ST_REM_RD: begin
            ram_addr = ptr_ff[AW-1:0];
            if (ptr_ff >= count_ff) begin
               count_in = wp_ff;
            end
         end
         chrl_pkg::ST_REM_WAIT: begin
            ptr_in = ptr_ff + 1'b1;
            if (rd_host != item_ff.host_id) begin
               ram_we    = 1'b1;
               ram_addr  = wp_ff[AW-1:0];
               ram_wdata = ram_rdata;
               wp_in     = wp_ff + 1'b1;
            end
         end
         chrl_pkg::ST_RESP: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chrl_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
      item_ff  <= item_in;
      out_ff   <= out_in;
      res_ff   <= res_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      ptr_ff   <= ptr_in;
      wp_ff    <= wp_in;
      byte_ff  <= byte_in;
      hash_ff  <= hash_in;
      carry_ff <= carry_in;
   end
endmodule

[sv/chrl_ram.sv]
// ----------------------------------------------------------------------------
// chrl_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module chrl_ram #(
   parameter int unsigned WIDTH = 39,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[verif/consistent_hash_ring_lookup_tb.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_tb
// Drives lookup, add and remove transfers into the ring block and checks
// every response against a queue-based model of the sorted ring. It covers
// directed corner cases, a sorted bulk fill, and random traffic.
// Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_tb;

   localparam int unsigned RING_CAP  = 4096;
   localparam int unsigned FILL_PTS  = 256;
   localparam logic [chrl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chrl_req_if req_ch ();
   chrl_rsp_if rsp_ch ();

   consistent_hash_ring_lookup uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #6 clock = ~clock;

   logic [chrl_pkg::HASH_W-1:0] ring_pos[$];
   logic [chrl_pkg::HOST_W-1:0] ring_owner[$];
   chrl_pkg::rsp_type           pending_rsp[$];
   int                error_count = 0;
   int                rsp_wait = 0;
   bit                rsp_stall_on = 1'b1;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
   end

   function automatic logic [chrl_pkg::HASH_W-1:0] key_hash_of(
      logic [chrl_pkg::KEY_W-1:0] key);
      logic [chrl_pkg::HASH_W-1:0] h;
      logic [7:0]                  b;
      h = '0;
      for (int i = 0; i < 8; i++) begin
         b = key[8*i +: 8];
         h = h + {{24{b[7]}}, b};
         h = h + (h << 10);
         h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
   endfunction

   function automatic chrl_pkg::rsp_type ring_apply(chrl_pkg::req_type r);
      chrl_pkg::rsp_type res;
      int                idx;
      res = '0;
      case (r.mode)
         chrl_pkg::MODE_LOOKUP: begin
            res.key_hash = key_hash_of(r.key_value);
            if (ring_pos.size() == 0) begin
               res.status = chrl_pkg::STAT_EMPTY;
            end else begin
               idx = 0;
               while (idx < ring_pos.size() && ring_pos[idx] < res.key_hash) idx++;
               if (idx >= ring_pos.size()) idx = 0;
               res.chosen_host = ring_owner[idx];
            end
         end
         chrl_pkg::MODE_ADD: begin
            if (ring_pos.size() >= RING_CAP) begin
               res.status = chrl_pkg::STAT_FULL;
            end else if (r.host_id != 0) begin
               idx = ring_pos.size();
               while (idx > 0 && ring_pos[idx-1] > r.point_hash) idx--;
               ring_pos.insert(idx, r.point_hash);
               ring_owner.insert(idx, r.host_id);
            end
         end
         chrl_pkg::MODE_REMOVE: begin
            for (int i = ring_pos.size() - 1; i >= 0; i--) begin
               if (ring_owner[i] == r.host_id) begin
                  ring_pos.delete(i);
                  ring_owner.delete(i);
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      chrl_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               report("unexpected transfer", 64'(rsp_ch.payload), 64'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_ch.payload.chosen_host !== want.chosen_host)
                  report("chosen_host", 64'(rsp_ch.payload.chosen_host),
                         64'(want.chosen_host));
               if (rsp_ch.payload.key_hash !== want.key_hash)
                  report("key_hash", 64'(rsp_ch.payload.key_hash), 64'(want.key_hash));
               if (rsp_ch.payload.status !== want.status)
                  report("status", 64'(rsp_ch.payload.status), 64'(want.status));
            end
            rsp_wait = rsp_stall_on ? $urandom_range(0, 8) : 0;
         end
         if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(chrl_pkg::req_type r, bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_rsp.push_back(ring_apply(r));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() > 0) @(posedge clock);
   endtask

   function automatic chrl_pkg::req_type make_req(logic [chrl_pkg::MODE_W-1:0] m,
                                                  logic [chrl_pkg::KEY_W-1:0] k,
                                                  logic [chrl_pkg::HASH_W-1:0] ph,
                                                  logic [chrl_pkg::HOST_W-1:0] h);
      chrl_pkg::req_type r;
      r.mode = m; r.key_value = k; r.point_hash = ph; r.host_id = h;
      return r;
   endfunction

   task automatic test_directed();
      send_item(make_req(chrl_pkg::MODE_LOOKUP, 64'h0, 32'h0, 7'd0));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, '1, '1, '1));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd5));
      send_item(make_req(MODE_UNUSED, '1, '1, '1));
      send_item(make_req(chrl_pkg::MODE_ADD, '0, 32'h1234, 7'd0));
      send_item(make_req(chrl_pkg::MODE_ADD, '0, 32'h8000_0000, 7'd1));
      send_item(make_req(chrl_pkg::MODE_ADD, '0, 32'h8000_0000, 7'd2));
      send_item(make_req(chrl_pkg::MODE_ADD, '0, 32'h8000_0000, 7'd3));
      send_item(make_req(chrl_pkg::MODE_ADD, '0, 32'h0, 7'd127));
      send_item(make_req(chrl_pkg::MODE_ADD, '0, '1, 7'd64));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, 64'h8080_8080_8080_8080, '0, '0));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, 64'h7f7f_7f7f_7f7f_7f7f, '0, '0));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, 64'h0123_4567_89ab_cdef, '0, '0));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd64));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, '1, '0, '0));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd0));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd2));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, 64'hfedc_ba98_7654_3210, '0, '0));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd127));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd1));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd3));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, 64'h55, '0, '0));
      drain();
   endtask

   task automatic test_fill_sorted();
      logic [chrl_pkg::HASH_W-1:0] ph;
      rsp_stall_on = 1'b0;
      for (int i = 0; i < FILL_PTS; i++) begin
         ph = (32'(i) << 24) | ($urandom & 32'h00ff_ffff);
         send_item(make_req(chrl_pkg::MODE_ADD, {$urandom, $urandom}, ph,
                            7'(i % 3 + 1)), i % 7 != 0);
      end
      rsp_stall_on = 1'b1;
      send_item(make_req(chrl_pkg::MODE_ADD, '0, '0, 7'd0));
      repeat (6) send_item(make_req(chrl_pkg::MODE_LOOKUP, {$urandom, $urandom}, '0, '0));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd2));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, {$urandom, $urandom}, '0, '0));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd1));
      send_item(make_req(chrl_pkg::MODE_REMOVE, '0, '0, 7'd3));
      send_item(make_req(chrl_pkg::MODE_LOOKUP, {$urandom, $urandom}, '0, '0));
      drain();
   endtask

   task automatic test_random(int count);
      chrl_pkg::req_type r;
      int                sel;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         rsp_stall_on = (n / 200) % 3 != 2;
         r.key_value  = {$urandom, $urandom};
         r.point_hash = $urandom;
         sel = $urandom_range(0, 99);
         r.host_id = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 12))
                                                : 7'($urandom_range(0, 127));
         if (sel < 45) begin
            r.mode = chrl_pkg::MODE_LOOKUP;
         end else if (sel < 50 || (ring_pos.size() > 48 && sel < 60)) begin
            r.mode = chrl_pkg::MODE_REMOVE;
            if (ring_owner.size() > 0 && sel < 48)
               r.host_id = ring_owner[$urandom_range(0, ring_owner.size() - 1)];
         end else if (sel < 98) begin
            r.mode = chrl_pkg::MODE_ADD;
            if (ring_pos.size() > 0 && $urandom_range(0, 4) == 0)
               r.point_hash = ring_pos[$urandom_range(0, ring_pos.size() - 1)];
         end else begin
            r.mode = MODE_UNUSED;
         end
         send_item(r);
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_sorted();
      test_random(1100);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(12 * 40000000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
